[design/sbr_pkg.sv]
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared widths, reset values, codes and state type of the scanline resampler.
// ----------------------------------------------------------------------------
package sbr_pkg;

   // Fixed field widths
   localparam int IDX_W   = 12;   // src_index, dest_index, out_index
   localparam int WIDTH_W = 13;   // src_width register
   localparam int SCALE_W = 28;   // scale_ratio register
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SCALE_W;

   // Parameter defaults
   localparam int LINE_MAX_DEF   = 4096;
   localparam int PIXEL_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // Register reset values
   localparam logic [WIDTH_W-1:0] SRC_WIDTH_RST   = WIDTH_W'(4096);
   localparam logic [SCALE_W-1:0] SCALE_RATIO_RST = SCALE_W'(65536);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_RATIO = 1'b1;

   // Beat commands
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADDR,
      ST_MIX,
      ST_DONE
   } state_type;

endpackage

[design/sbr_req_if.sv]
// ----------------------------------------------------------------------------
// sbr_req_if
// Request channel: load and compute beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbr_req_if
   import sbr_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [IDX_W-1:0]      src_index;
   logic [PIXEL_BITS-1:0] src_pixel;
   logic [IDX_W-1:0]      dest_index;

   modport source (output valid, cmd, src_index, src_pixel, dest_index, input ready);
   modport sink   (input valid, cmd, src_index, src_pixel, dest_index, output ready);
endinterface

[design/sbr_rsp_if.sv]
// ----------------------------------------------------------------------------
// sbr_rsp_if
// Response channel: interpolated pixel beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbr_rsp_if
   import sbr_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] out_pixel;
   logic [IDX_W-1:0]      out_index;

   modport source (output valid, out_pixel, out_index, input ready);
   modport sink   (input valid, out_pixel, out_index, output ready);
endinterface

[design/sbr_ram.sv]
// ----------------------------------------------------------------------------
// sbr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sbr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[design/sbr_addr_gen.sv]
// ----------------------------------------------------------------------------
// sbr_addr_gen
// Source position multiply, then split into clamped tap addresses and fraction.
// ----------------------------------------------------------------------------
module sbr_addr_gen
   import sbr_pkg::*;
#(
   parameter int LINE_MAX  = LINE_MAX_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        mul_en,
   input  logic [IDX_W-1:0]            dest_index,
   input  logic [SCALE_W-1:0]          scale_ratio,
   input  logic [WIDTH_W-1:0]          src_width,
   output logic [$clog2(LINE_MAX)-1:0] p1,
   output logic [$clog2(LINE_MAX)-1:0] p2,
   output logic [FRAC_BITS-1:0]        frac
);
   localparam int ADDR_W = $clog2(LINE_MAX);
   localparam int PROD_W = IDX_W + 1 + SCALE_W;
   localparam int POS_W  = PROD_W - 1;
   localparam int P_W    = POS_W - FRAC_BITS;
   localparam int LIM_W  = ($clog2(LINE_MAX + 1) > WIDTH_W) ? $clog2(LINE_MAX + 1) : WIDTH_W;

   logic [PROD_W-1:0] prod_ff;
   logic [POS_W-1:0]  pos;
   logic [P_W-1:0]    p1_full;
   logic [LIM_W-1:0]  width_eff;
   logic [ADDR_W-1:0] max_idx;

   // (x + 0.5) * scale as ((2x + 1) * scale) >> 1
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= PROD_W'({dest_index, 1'b1}) * PROD_W'(scale_ratio);
      end
   end

   always_comb begin
      width_eff = LIM_W'(src_width);
      if (width_eff == '0) begin
         width_eff = LIM_W'(1);
      end
      if (width_eff > LIM_W'(LINE_MAX)) begin
         width_eff = LIM_W'(LINE_MAX);
      end
      max_idx = ADDR_W'(width_eff - LIM_W'(1));

      pos     = prod_ff[PROD_W-1:1];
      p1_full = pos[POS_W-1:FRAC_BITS];
      frac    = pos[FRAC_BITS-1:0];

      if (p1_full > P_W'(max_idx)) begin
         p1 = max_idx;
      end else begin
         p1 = ADDR_W'(p1_full);
      end
      p2 = (p1 == max_idx) ? max_idx : p1 + ADDR_W'(1);
   end
endmodule

[design/sbr_blend.sv]
// ----------------------------------------------------------------------------
// sbr_blend
// Weighted blend of two neighbor pixels with round-half-up.
// ----------------------------------------------------------------------------
module sbr_blend
   import sbr_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  mix_en,
   input  logic [PIXEL_BITS-1:0] pix_a,
   input  logic [PIXEL_BITS-1:0] pix_b,
   input  logic [FRAC_BITS-1:0]  frac,
   output logic [PIXEL_BITS-1:0] out_pixel
);
   localparam int DIFF_W = PIXEL_BITS + 1;
   localparam int MIX_W  = PIXEL_BITS + FRAC_BITS + 2;
   localparam logic signed [MIX_W-1:0] RND_HALF = MIX_W'(64'd1 << (FRAC_BITS - 1));

   logic signed [DIFF_W-1:0] diff;
   logic signed [MIX_W-1:0]  mix_ff;
   logic [PIXEL_BITS-1:0]    pix_a_ff;
   logic signed [MIX_W-1:0]  rounded;
   logic signed [MIX_W-1:0]  shifted;

   assign diff = $signed({1'b0, pix_b}) - $signed({1'b0, pix_a});

   always_ff @(posedge clock) begin
      if (mix_en) begin
         mix_ff   <= MIX_W'(diff * $signed({1'b0, frac}));
         pix_a_ff <= pix_a;
      end
   end

   // a + floor(((b - a) * f + half) / 2^F); the sum stays between a and b
   always_comb begin
      rounded   = mix_ff + RND_HALF;
      shifted   = rounded >>> FRAC_BITS;
      out_pixel = pix_a_ff + shifted[PIXEL_BITS-1:0];
   end
endmodule

[design/scanline_bilinear_resample.sv]
// ----------------------------------------------------------------------------
// scanline_bilinear_resample
// Horizontal bilinear resampler for one scanline held in an on-chip line store.
// ----------------------------------------------------------------------------
// Send load beats (cmd = 0) to fill the line store with source pixels, then
// compute beats (cmd = 1) to get one interpolated pixel each, echoed with its
// output index. A load produces no response beat. A compute holds the request
// side from acceptance through the multiply, the address split with the line
// store read, the blend and the output step; the output step waits while a
// stalled response still sits in the output register. A finished response may
// sit in the output register while the next request is taken. The line store
// is not cleared by reset: read only positions that were loaded.
// Write csr registers only while the block is idle.
// ----------------------------------------------------------------------------
module scanline_bilinear_resample
   import sbr_pkg::*;
#(
   parameter int LINE_MAX   = LINE_MAX_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sbr_req_if.sink               req_bus,
   sbr_rsp_if.source             rsp_bus,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);
   localparam int ADDR_W = $clog2(LINE_MAX);

   state_type state_ff, state_in;

   logic [WIDTH_W-1:0]    src_width_ff;
   logic [SCALE_W-1:0]    scale_ratio_ff;
   logic [IDX_W-1:0]      dest_index_ff;
   logic [FRAC_BITS-1:0]  frac_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_BITS-1:0] out_pixel_ff;
   logic [IDX_W-1:0]      out_index_ff;

   logic                  req_beat;
   logic                  load_wr;
   logic                  mul_en;
   logic                  rd_en;
   logic                  mix_en;
   logic                  out_load;

   logic [ADDR_W-1:0]     p1;
   logic [ADDR_W-1:0]     p2;
   logic [FRAC_BITS-1:0]  frac;
   logic [PIXEL_BITS-1:0] pix_a;
   logic [PIXEL_BITS-1:0] pix_b;
   logic [PIXEL_BITS-1:0] blend_pixel;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= SRC_WIDTH_RST;
         scale_ratio_ff <= SCALE_RATIO_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SRC_WIDTH:   src_width_ff   <= csr_write_data[WIDTH_W-1:0];
            CSR_SCALE_RATIO: scale_ratio_ff <= csr_write_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Take a request beat only when the sequencer is free
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_beat      = req_bus.valid && req_bus.ready;

   // Drop loads that land past the end of the line store
   assign load_wr = req_beat && (req_bus.cmd == CMD_LOAD)
                    && (32'(req_bus.src_index) < LINE_MAX);

   // Sequencer: next state and stage enables
   always_comb begin
      state_in = state_ff;
      mul_en   = 1'b0;
      rd_en    = 1'b0;
      mix_en   = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_bus.cmd == CMD_COMPUTE)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_en   = 1'b1;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            rd_en    = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            mix_en   = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free or being drained
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the requested index on acceptance and the fraction alongside the tap reads
   always_ff @(posedge clock) begin
      if (req_beat && (req_bus.cmd == CMD_COMPUTE)) begin
         dest_index_ff <= req_bus.dest_index;
      end
      if (rd_en) begin
         frac_ff <= frac;
      end
   end

   sbr_addr_gen #(
      .LINE_MAX  (LINE_MAX),
      .FRAC_BITS (FRAC_BITS)
   ) u_addr_gen (
      .clock       (clock),
      .mul_en      (mul_en),
      .dest_index  (dest_index_ff),
      .scale_ratio (scale_ratio_ff),
      .src_width   (src_width_ff),
      .p1          (p1),
      .p2          (p2),
      .frac        (frac)
   );

   // Two copies of the line store, one per tap, both written by every load that lands inside it
   sbr_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (LINE_MAX)
   ) u_line_a (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (ADDR_W'(req_bus.src_index)),
      .wr_data (req_bus.src_pixel),
      .rd_en   (rd_en),
      .rd_addr (p1),
      .rd_data (pix_a)
   );

   sbr_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (LINE_MAX)
   ) u_line_b (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (ADDR_W'(req_bus.src_index)),
      .wr_data (req_bus.src_pixel),
      .rd_en   (rd_en),
      .rd_addr (p2),
      .rd_data (pix_b)
   );

   sbr_blend #(
      .PIXEL_BITS (PIXEL_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_blend (
      .clock     (clock),
      .mix_en    (mix_en),
      .pix_a     (pix_a),
      .pix_b     (pix_b),
      .frac      (frac_ff),
      .out_pixel (blend_pixel)
   );

   // Output register: load on finish, clear once the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pixel_ff <= blend_pixel;
         out_index_ff <= dest_index_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_pixel = out_pixel_ff;
   assign rsp_bus.out_index = out_index_ff;

`ifndef ASSERT_OFF
   // A compute beat always starts the multiply stage next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_bus.cmd == CMD_COMPUTE)) |=> (state_ff == ST_MUL))
      else $error("compute beat did not start the sequencer");

   // The second tap is the first one or its right neighbor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADDR) |-> ((p2 == p1) || (p2 == p1 + ADDR_W'(1))))
      else $error("tap addresses are not adjacent");

   // A response appears only when the sequencer finishes a compute
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised without a finished compute");

   // No response is dropped: finishing while a stalled beat waits is illegal
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("output register overwritten while holding a beat");
`endif
endmodule

[dv/sbr_resample_check_pkg.sv]
// ----------------------------------------------------------------------------
// sbr_resample_check_pkg
// Line store mirror, bilinear pixel prediction and response checking.
// ----------------------------------------------------------------------------
package sbr_resample_check_pkg;
   import sbr_pkg::*;

   localparam logic [63:0] FRAC_ONE = 64'd1 << FRAC_BITS_DEF;

   typedef struct packed {
      logic [PIXEL_BITS_DEF-1:0] pixel;
      logic [IDX_W-1:0]          index;
   } out_beat_type;

   class resample_checker;
      logic [PIXEL_BITS_DEF-1:0] line_px [LINE_MAX_DEF];
      logic [WIDTH_W-1:0]        width_reg;
      logic [SCALE_W-1:0]        scale_reg;
      out_beat_type              pending_pixels [$];
      int unsigned               mismatches;

      function new();
         width_reg  = SRC_WIDTH_RST;
         scale_reg  = SCALE_RATIO_RST;
         mismatches = 0;
         foreach (line_px[i]) line_px[i] = '0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_SRC_WIDTH) begin
            width_reg = data[WIDTH_W-1:0];
         end else begin
            scale_reg = data[SCALE_W-1:0];
         end
      endfunction

      // Source taps and blend weight for output position x under the
      // current registers; the position never wraps, only the taps clamp.
      function void taps(input logic [IDX_W-1:0] x, output int unsigned p1,
                         output int unsigned p2,
                         output logic [FRAC_BITS_DEF-1:0] frac);
         logic [63:0] pos;
         int unsigned last;
         if (width_reg == 0) last = 0;
         else if (width_reg > LINE_MAX_DEF) last = LINE_MAX_DEF - 1;
         else last = width_reg - 1;
         pos  = ((64'(x) * 2 + 1) * 64'(scale_reg)) >> 1;
         frac = pos[FRAC_BITS_DEF-1:0];
         pos  = pos >> FRAC_BITS_DEF;
         p1   = (pos > 64'(last)) ? last : 32'(pos);
         p2   = (p1 + 1 > last) ? last : p1 + 1;
      endfunction

      function void note_beat(input logic cmd, input logic [IDX_W-1:0] src_index,
                              input logic [PIXEL_BITS_DEF-1:0] src_pixel,
                              input logic [IDX_W-1:0] dest_index);
         int unsigned p1, p2;
         logic [FRAC_BITS_DEF-1:0] f;
         logic [63:0] sum;
         out_beat_type e;
         if (cmd == CMD_LOAD) begin
            line_px[src_index] = src_pixel;
            return;
         end
         taps(dest_index, p1, p2, f);
         sum = 64'(line_px[p1]) * (FRAC_ONE - 64'(f)) + 64'(line_px[p2]) * 64'(f)
               + (FRAC_ONE >> 1);
         e.pixel = sum[FRAC_BITS_DEF +: PIXEL_BITS_DEF];
         e.index = dest_index;
         pending_pixels.insert(pending_pixels.size(), e);
      endfunction

      function void flag(input string what, input logic [31:0] want,
                         input logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, what, want, got);
      endfunction

      function void check_beat(input logic [PIXEL_BITS_DEF-1:0] pixel,
                               input logic [IDX_W-1:0] index);
         out_beat_type e;
         if (pending_pixels.size() == 0) begin
            flag("unexpected response beat, out_index", '0, 32'(index));
            return;
         end
         e = pending_pixels.pop_front();
         if (e.pixel !== pixel) flag("out_pixel", 32'(e.pixel), 32'(pixel));
         if (e.index !== index) flag("out_index", 32'(e.index), 32'(index));
      endfunction
   endclass

endpackage

[dv/tb_scanline_bilinear_resample.sv]
// ----------------------------------------------------------------------------
// tb_scanline_bilinear_resample
// Self-checking bench for the scanline bilinear resampler. Load and compute
// beats go in under random idling on both sides; every response beat is
// compared with a prediction from a mirror of the line store and registers.
// ----------------------------------------------------------------------------
module tb_scanline_bilinear_resample;
   timeunit 1ns;
   timeprecision 1ps;

   import sbr_pkg::*;
   import sbr_resample_check_pkg::*;

   // Cycles to let a load or an in-flight compute settle before a csr write
   // or the final verdict.
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASES       = 8;
   localparam int PHASE_BEATS  = 120;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   sbr_req_if #(.PIXEL_BITS(PIXEL_BITS_DEF)) req_bus ();
   sbr_rsp_if #(.PIXEL_BITS(PIXEL_BITS_DEF)) rsp_bus ();

   scanline_bilinear_resample uut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   resample_checker sb;

   // Line store entries the bench has filled; a compute never taps any other.
   bit loaded [LINE_MAX_DEF];

   // Percent of cycles in which the sender idles and the receiver stalls.
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Receiver: toss ready each cycle and check every response beat taken.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_beat(rsp_bus.out_pixel, rsp_bus.out_index);
   end

   function automatic logic [PIXEL_BITS_DEF-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIXEL_BITS_DEF'($urandom);
      endcase
   endfunction

   // Offer one beat, idling first at random, and note it once accepted.
   // Valid stays high after acceptance so back-to-back beats have no gap.
   task automatic send_beat(input logic cmd, input logic [IDX_W-1:0] si,
                            input logic [PIXEL_BITS_DEF-1:0] sp,
                            input logic [IDX_W-1:0] di);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.src_index  <= si;
      req_bus.src_pixel  <= sp;
      req_bus.dest_index <= di;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_beat(cmd, si, sp, di);
   endtask

   // Load one pixel; the unused dest_index field carries noise.
   task automatic load_pixel(input int unsigned idx, input logic [PIXEL_BITS_DEF-1:0] pix);
      send_beat(CMD_LOAD, IDX_W'(idx), pix, IDX_W'($urandom));
      loaded[idx] = 1'b1;
   endtask

   // Compute one output pixel, first loading any tap never written.
   task automatic compute_pixel(input int unsigned x);
      int unsigned p1, p2;
      logic [FRAC_BITS_DEF-1:0] f;
      sb.taps(IDX_W'(x), p1, p2, f);
      if (!loaded[p1]) load_pixel(p1, pick_pixel());
      if (!loaded[p2]) load_pixel(p2, pick_pixel());
      send_beat(CMD_COMPUTE, IDX_W'($urandom), PIXEL_BITS_DEF'($urandom), IDX_W'(x));
   endtask

   // Drop valid and hold until no response is owed and the pipe is empty.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers while idle; noise in the unused width bits is
   // dropped by the block.
   task automatic configure(input int unsigned w, input logic [SCALE_W-1:0] s);
      logic [CSR_DATA_W-1:0] wdata;
      wdata = {CSR_DATA_W'($urandom)} & ~CSR_DATA_W'({WIDTH_W{1'b1}});
      wdata = wdata | CSR_DATA_W'(WIDTH_W'(w));
      drain();
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_SRC_WIDTH;
      csr_write_data <= wdata;
      @(posedge clock);
      csr_index      <= CSR_SCALE_RATIO;
      csr_write_data <= CSR_DATA_W'(s);
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.write_reg(CSR_SRC_WIDTH, wdata);
      sb.write_reg(CSR_SCALE_RATIO, CSR_DATA_W'(s));
   endtask

   // Random registers, weighted toward the clamp corners, then a mix of
   // overwriting loads and computes over the whole index range and near zero.
   task automatic random_phase();
      int unsigned w;
      logic [SCALE_W-1:0] s;
      case ($urandom_range(0, 5))
         0:       w = 1;
         1:       w = 2;
         2:       w = LINE_MAX_DEF;
         3:       w = (1 << WIDTH_W) - 1;
         4:       w = 0;
         default: w = $urandom_range(1, LINE_MAX_DEF);
      endcase
      case ($urandom_range(0, 4))
         0:       s = '0;
         1:       s = '1;
         default: s = SCALE_W'($urandom_range(1, 32'h3FFFF));
      endcase
      configure(w, s);
      repeat (PHASE_BEATS) begin
         if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 1) != 0) load_pixel($urandom_range(0, 4095), pick_pixel());
            else load_pixel($urandom_range(0, 255), pick_pixel());
         end else begin
            if ($urandom_range(0, 1) != 0) compute_pixel($urandom_range(0, 4095));
            else compute_pixel($urandom_range(0, 255));
         end
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct      = 21;
      rsp_stall_pct      = 78;
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_LOAD;
      req_bus.src_index  = '0;
      req_bus.src_pixel  = '0;
      req_bus.dest_index = '0;
      rsp_bus.ready      = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: unity scale over the full line. Extreme pixels at
      // both ends; x = 0 blends the first two halfway, x = 4095 clamps.
      load_pixel(0, '0);
      load_pixel(1, '1);
      load_pixel(2, 16'h8000);
      load_pixel(4094, '0);
      load_pixel(4095, '1);
      compute_pixel(0);
      compute_pixel(1);
      compute_pixel(4094);
      compute_pixel(4095);

      // Zero width acts as one pixel; zero scale pins the position at zero.
      configure(0, '0);
      compute_pixel(0);
      compute_pixel(4095);

      // Oversize width acts as the full line; the largest scale drives the
      // position far past the end without wrapping.
      configure((1 << WIDTH_W) - 1, '1);
      compute_pixel(0);
      compute_pixel(4095);

      // Odd scale: the half-step position loses its half LSB to truncation.
      configure(LINE_MAX_DEF, 28'd1);
      compute_pixel(1);
      compute_pixel(4095);
      configure(3, 28'h8001);
      compute_pixel(2);
      compute_pixel(7);

      // Random part: swap the idling sides after three phases, then run flat.
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 78;
            rsp_stall_pct = 21;
         end else if (ph == 6) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         random_phase();
      end

      drain();
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[scanline_bilinear_resample.f]
design/sbr_pkg.sv
design/sbr_req_if.sv
design/sbr_rsp_if.sv
design/sbr_ram.sv
design/sbr_addr_gen.sv
design/sbr_blend.sv
design/scanline_bilinear_resample.sv
dv/sbr_resample_check_pkg.sv
dv/tb_scanline_bilinear_resample.sv
